@@ sv/hjt_pkg.sv @@
// hjt_pkg: types and constants for the hash join table.
// Used by hjt_ctrl, hjt_datapath and hash_join_table; depends on nothing.
package hjt_pkg;

  localparam int CFG_W  = 4;
  localparam int FUNC_W = 2;
  localparam int KEY_W  = 32;
  localparam int PAY_W  = 64;
  localparam int ST_W   = 3;
  localparam int CNT_W  = 31;
  localparam int MIN_LG = 10;

  localparam logic [CFG_W-1:0] LG_RESET = CFG_W'(12);
  localparam logic [KEY_W-1:0] FMIX_C1  = 32'h85ebca6b;
  localparam logic [KEY_W-1:0] FMIX_C2  = 32'hc2b2ae35;
  localparam logic [CNT_W-1:0] CNT_MAX  = {CNT_W{1'b1}};

  localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_PROBE  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;

  localparam logic [ST_W-1:0] STAT_NEW       = 3'd0;
  localparam logic [ST_W-1:0] STAT_OVERWRITE = 3'd1;
  localparam logic [ST_W-1:0] STAT_FOUND     = 3'd2;
  localparam logic [ST_W-1:0] STAT_NOT_FOUND = 3'd3;
  localparam logic [ST_W-1:0] STAT_FULL      = 3'd4;
  localparam logic [ST_W-1:0] STAT_CLEARED   = 3'd5;

  typedef struct packed {
    logic [FUNC_W-1:0]       func;
    logic signed [KEY_W-1:0] key;
    logic signed [PAY_W-1:0] payload;
    logic                    last_in_batch;
  } in_word_t;

  typedef struct packed {
    logic [ST_W-1:0]         status;
    logic signed [PAY_W-1:0] found_payload;
    logic [CNT_W-1:0]        row_index;
    logic [CNT_W-1:0]        match_count;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_HASH1,
    ST_HASH2,
    ST_HASH3,
    ST_WALK,
    ST_SWEEP,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load_in;
    logic start_walk;
    logic advance;
    logic sweep;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic decide;
    logic sweep_last;
    logic out_free;
  } stat_t;

endpackage

@@ sv/hjt_ctrl.sv @@
// hjt_ctrl: sequencer for the hash join table (hash, slot walk, clear sweep).
// Depends on hjt_pkg; drives hjt_datapath through cmd_t and reads stat_t.
module hjt_ctrl
  import hjt_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [FUNC_W-1:0] in_func,
  output logic              in_stall,
  input  stat_t             stat,
  output cmd_t              cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_INIT: begin
        if (stat.sweep_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          if (in_func inside {FUNC_INSERT, FUNC_PROBE}) begin
            state_next = ST_HASH1;
          end else if (in_func == FUNC_CLEAR) begin
            state_next = ST_SWEEP;
          end else begin
            state_next = ST_FINISH;
          end
        end
      end
      ST_HASH1: state_next = ST_HASH2;
      ST_HASH2: state_next = ST_HASH3;
      ST_HASH3: state_next = ST_WALK;
      ST_WALK: begin
        if (stat.decide && stat.out_free) state_next = ST_IDLE;
      end
      ST_SWEEP: begin
        if (stat.sweep_last) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (stat.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_INIT;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state)
      ST_INIT:  cmd.sweep = 1'b1;
      ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.load_in = in_valid;
      end
      ST_HASH3: cmd.start_walk = 1'b1;
      ST_WALK: begin
        cmd.emit    = stat.decide && stat.out_free;
        cmd.advance = !stat.decide;
      end
      ST_SWEEP:  cmd.sweep = 1'b1;
      ST_FINISH: cmd.emit  = stat.out_free;
      default: cmd = '0;
    endcase
  end

`ifndef SYNTHESIS
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> stat.out_free)
    else $error("result emitted while output register busy");

  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load_in, cmd.start_walk, cmd.advance, cmd.sweep, cmd.emit}))
    else $error("more than one datapath command");

  a_walk_go_on: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK) && !stat.decide |=> (state == ST_WALK))
    else $error("walk left before a decision");

  a_init_done: assert property (@(posedge clk) disable iff (rst)
    (state == ST_INIT) && stat.sweep_last |=> (state == ST_IDLE))
    else $error("reset sweep did not end in idle");

  a_hash_walk: assert property (@(posedge clk) disable iff (rst)
    cmd.start_walk |=> (state == ST_WALK))
    else $error("walk did not follow hash");
`endif

endmodule

@@ sv/hjt_datapath.sv @@
// hjt_datapath: hash pipeline, slot memory, walk index, batch counters, result word.
// Depends on hjt_pkg; commanded by hjt_ctrl.
module hjt_datapath
  import hjt_pkg::*;
#(
  parameter int TABLE_DEPTH = 4096
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  input  in_word_t         in_word,
  input  logic             out_stall,
  output logic             out_valid,
  output out_word_t        out_word,
  input  cmd_t             cmd,
  output stat_t            stat
);

  localparam int AW     = $clog2(TABLE_DEPTH);
  localparam int MAX_LG = $clog2(TABLE_DEPTH + 1) - 1;
  localparam int LG_W   = $clog2(MAX_LG + 1);

  typedef struct packed {
    logic             used;
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
  } slot_t;

  slot_t mem [TABLE_DEPTH];
  slot_t rd_data;
  slot_t wr_data;

  logic [CFG_W-1:0]  size_log2;
  logic [FUNC_W-1:0] func_r;
  logic [KEY_W-1:0]  key_r;
  logic [PAY_W-1:0]  payload_r;
  logic              last_r;
  logic [KEY_W-1:0]  m1;
  logic [KEY_W-1:0]  m2;
  logic [AW-1:0]     idx;
  logic [AW-1:0]     walk_n;
  logic [AW-1:0]     sweep_addr;
  logic [CNT_W-1:0]  row_cnt;
  logic [CNT_W-1:0]  match_cnt;

  logic [LG_W-1:0]  lg_eff;
  logic [AW-1:0]    mask;
  logic [KEY_W-1:0] x1;
  logic [KEY_W-1:0] x2;
  logic [KEY_W-1:0] x3;
  logic [AW-1:0]    home;
  logic [AW-1:0]    rd_addr;
  logic [AW-1:0]    wr_addr;
  logic             wr_en;
  logic             key_hit;
  logic             is_probe;
  logic [ST_W-1:0]  res_status;
  logic [CNT_W-1:0] row_inc;
  logic [CNT_W-1:0] match_new;
  out_word_t        res;

  always_comb begin
    if (size_log2 < CFG_W'(MIN_LG)) begin
      lg_eff = LG_W'(MIN_LG);
    end else if (int'(size_log2) > MAX_LG) begin
      lg_eff = LG_W'(MAX_LG);
    end else begin
      lg_eff = LG_W'(size_log2);
    end
  end

  assign mask = ~({AW{1'b1}} << lg_eff);

  assign x1   = key_r ^ (key_r >> 16);
  assign x2   = m1 ^ (m1 >> 13);
  assign x3   = m2 ^ (m2 >> 16);
  assign home = x3[AW-1:0] & mask;

  always_comb begin
    if (cmd.start_walk) begin
      rd_addr = home;
    end else if (cmd.advance) begin
      rd_addr = (idx + AW'(1)) & mask;
    end else begin
      rd_addr = idx;
    end
  end

  assign key_hit  = rd_data.used && (rd_data.key == key_r);
  assign is_probe = (func_r == FUNC_PROBE);

  always_comb begin
    case (func_r)
      FUNC_INSERT: begin
        if (!rd_data.used)  res_status = STAT_NEW;
        else if (key_hit)   res_status = STAT_OVERWRITE;
        else                res_status = STAT_FULL;
      end
      FUNC_PROBE: begin
        if (!rd_data.used)  res_status = STAT_NOT_FOUND;
        else if (key_hit)   res_status = STAT_FOUND;
        else                res_status = STAT_FULL;
      end
      FUNC_CLEAR: res_status = STAT_CLEARED;
      default:    res_status = STAT_NOT_FOUND;
    endcase
  end

  assign row_inc   = (row_cnt == CNT_MAX) ? row_cnt : row_cnt + CNT_W'(1);
  assign match_new = (res_status == STAT_FOUND) ?
                     ((match_cnt == CNT_MAX) ? match_cnt : match_cnt + CNT_W'(1)) :
                     match_cnt;

  always_comb begin
    res.status        = res_status;
    res.found_payload = (res_status == STAT_FOUND) ? rd_data.payload : '0;
    res.row_index     = is_probe ? row_cnt : '0;
    res.match_count   = is_probe ? match_new : '0;
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx;
    wr_data = '{used: 1'b1, key: key_r, payload: payload_r};
    if (cmd.sweep) begin
      wr_en   = 1'b1;
      wr_addr = sweep_addr;
      wr_data = '0;
    end else if (cmd.emit && (func_r == FUNC_INSERT) &&
                 ((res_status == STAT_NEW) || (res_status == STAT_OVERWRITE))) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    m1 <= 32'(x1 * FMIX_C1);
    m2 <= 32'(x2 * FMIX_C2);
    if (cmd.load_in) begin
      func_r    <= in_word.func;
      key_r     <= in_word.key;
      payload_r <= in_word.payload;
      last_r    <= in_word.last_in_batch;
    end
    if (cmd.start_walk || cmd.advance) begin
      idx <= rd_addr;
    end
    if (cmd.start_walk) begin
      walk_n <= '0;
    end else if (cmd.advance) begin
      walk_n <= walk_n + AW'(1);
    end
    if (cmd.emit) begin
      out_word <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      size_log2  <= LG_RESET;
      sweep_addr <= '0;
      row_cnt    <= '0;
      match_cnt  <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        size_log2 <= cfg_wdata;
      end
      if (cmd.sweep) begin
        sweep_addr <= stat.sweep_last ? '0 : sweep_addr + AW'(1);
      end
      if (cmd.emit) begin
        if (last_r) begin
          row_cnt   <= '0;
          match_cnt <= '0;
        end else if (is_probe) begin
          row_cnt   <= row_inc;
          match_cnt <= match_new;
        end
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign stat.decide     = !rd_data.used || key_hit || (walk_n == mask);
  assign stat.sweep_last = (sweep_addr == AW'(TABLE_DEPTH - 1));
  assign stat.out_free   = !out_valid || !out_stall;

endmodule

@@ sv/hash_join_table.sv @@
// hash_join_table: top level of the linear-probing hash table for joins.
// Depends on hjt_pkg, hjt_ctrl and hjt_datapath.
//
//   channel | signals                      | word
//   --------+------------------------------+------------
//   input   | in_valid, in_stall, in_word  | in_word_t
//   output  | out_valid, out_stall, out_word | out_word_t
//   config  | cfg_we, cfg_wdata            | 4-bit size_log2
//
// Insert or probe: after the hash pipeline (states HASH1, HASH2, HASH3) the walk visits one slot
// per cycle through the registered read port of the slot memory.
// Clear: one slot cleared per cycle over the whole table; other codes go straight to the result.
// After reset a sweep over all TABLE_DEPTH slots empties the table; in_stall stays high.
// A finished result waits in the output register while out_stall is high.
module hash_join_table
  import hjt_pkg::*;
#(
  parameter int TABLE_DEPTH = 4096
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_word_t         in_word,
  output logic             out_valid,
  input  logic             out_stall,
  output out_word_t        out_word
);

  cmd_t  cmd;
  stat_t stat;

  hjt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_func  (in_word.func),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  hjt_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_word   (in_word),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_word  (out_word),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule
